[sv/ace_pkg.sv]
// ----------------------------------------------------------------------------
// ace_pkg: shared types and constants for the arithmetic interval encoder
// Holds widths, interval constants, channel structs and the control/status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package ace_pkg;

   localparam int CODE_BITS    = 16;
   localparam int FREQ_BITS    = 14;
   localparam int PENDING_BITS = 16;
   localparam int FOLLOW_W     = 16;
   localparam int MAX_RESULTS  = 16;

   localparam int RANGE_W    = CODE_BITS + 1;
   localparam int TOT_W      = FREQ_BITS + 1;
   localparam int PROD_W     = RANGE_W + TOT_W;
   localparam int QUOT_W     = RANGE_W;
   localparam int REM_W      = TOT_W + 1;
   localparam int DIV_CNT_W  = $clog2(PROD_W);
   localparam int RES_CNT_W  = $clog2(MAX_RESULTS + 1);
   localparam int PEND_EXT_W = (PENDING_BITS > FOLLOW_W) ? PENDING_BITS : FOLLOW_W;

   localparam logic [CODE_BITS-1:0] CODE_TOP      = {CODE_BITS{1'b1}};
   localparam logic [CODE_BITS-1:0] AR_HALF       = {1'b1, {(CODE_BITS-1){1'b0}}};
   localparam logic [CODE_BITS-1:0] FIRST_QUARTER = {2'b01, {(CODE_BITS-2){1'b0}}};
   localparam logic [CODE_BITS-1:0] THIRD_QUARTER = {2'b11, {(CODE_BITS-2){1'b0}}};
   localparam logic [PENDING_BITS-1:0] PEND_MAX  = {PENDING_BITS{1'b1}};
   localparam logic [TOT_W-1:0] FREQ_LIMIT       = {1'b1, {FREQ_BITS{1'b0}}};
   localparam logic [FOLLOW_W-1:0] FOLLOW_MAX    = {FOLLOW_W{1'b1}};
   localparam logic [RES_CNT_W-1:0] RES_CAP      = RES_CNT_W'(MAX_RESULTS);

   localparam logic KIND_SYMBOL = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [FREQ_BITS-1:0] cum_below;
      logic [TOT_W-1:0]     cum_through;
      logic [TOT_W-1:0]     freq_total;
   } ace_req_type;

   typedef struct packed {
      logic                code_bit;
      logic [FOLLOW_W-1:0] follow_count;
      logic                pending_overflow;
      logic                last;
   } ace_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_START,
      ST_DIV,
      ST_NARROW,
      ST_RENORM,
      ST_FLUSH,
      ST_DRAIN
   } ace_state_type;

   typedef enum logic [1:0] {
      STEP_EMIT0,
      STEP_EMIT1,
      STEP_PEND,
      STEP_DONE
   } ace_step_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_start;
      logic narrow;
      logic step;
      logic flush;
      logic drain;
   } ace_cmd_type;

   typedef struct packed {
      logic         req_flush;
      logic         req_sym_ok;
      logic         finished;
      logic         div_busy;
      logic         q_ok;
      ace_step_type step;
      logic         hold_valid;
      logic         hold_cap;
      logic         out_free;
   } ace_status_type;

   // one emitted bit with its follow count, saturated to the field width
   function automatic ace_rsp_type make_rsp(input logic bit_val,
                                            input logic [PENDING_BITS-1:0] pend,
                                            input logic sat);
      ace_rsp_type r;
      logic [PEND_EXT_W-1:0] ext;
      logic big;
      ext = PEND_EXT_W'(pend);
      big = ext > PEND_EXT_W'(FOLLOW_MAX);
      r.code_bit         = bit_val;
      r.follow_count     = big ? FOLLOW_MAX : FOLLOW_W'(ext);
      r.pending_overflow = sat | big;
      r.last             = 1'b0;
      return r;
   endfunction

endpackage

[sv/ace_div.sv]
// ----------------------------------------------------------------------------
// ace_div: restoring divider, one quotient bit per cycle
// Divides the product by the model total; busy stays high until the last quotient bit is in.
// ----------------------------------------------------------------------------
module ace_div import ace_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [PROD_W-1:0] dividend,
   input  logic [TOT_W-1:0]  divisor,
   output logic [QUOT_W-1:0] quotient,
   output logic              busy
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [TOT_W-1:0]     dvs_ff, dvs_in;
   logic [REM_W-1:0]     rem_sh;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-2:0], acc_ff[PROD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(PROD_W - 1);
         acc_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PROD_W-2:0], ge};
         rem_in = ge ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = acc_ff[QUOT_W-1:0];
   assign busy     = busy_ff;

endmodule

[sv/ace_dp.sv]
// ----------------------------------------------------------------------------
// ace_dp: interval encoder datapath
// Interval and pending registers, multiply and divide, renormalization step,
// one-deep hold stage for the last flag and the result output register.
// ----------------------------------------------------------------------------
module ace_dp import ace_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  ace_cmd_type    cmd,
   output ace_status_type status,
   input  ace_req_type    req_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output ace_rsp_type    rsp_data
);

   logic [CODE_BITS-1:0]    low_ff, low_in, high_ff, high_in;
   logic [PENDING_BITS-1:0] pend_ff, pend_in;
   logic                    sat_ff, sat_in;
   logic                    finished_ff, finished_in;
   logic [RANGE_W-1:0]      range_ff, range_in;
   logic [FREQ_BITS-1:0]    cb_ff, cb_in;
   logic [TOT_W-1:0]        ct_ff, ct_in, tot_ff, tot_in;
   logic [PROD_W-1:0]       prod_hi_ff, prod_hi_in, prod_lo_ff, prod_lo_in;
   logic                    hold_valid_ff, hold_valid_in;
   ace_rsp_type             hold_ff, hold_in;
   logic [RES_CNT_W-1:0]    count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   ace_rsp_type             rsp_data_ff, rsp_data_in;

   logic [QUOT_W-1:0]       qhi, qlo;
   logic                    busy_hi, busy_lo;
   logic [RANGE_W-1:0]      high_wide;
   ace_step_type            step;
   logic [CODE_BITS-1:0]    low_adj, high_adj;
   logic [PENDING_BITS-1:0] pinc;
   logic                    pinc_sat;
   logic                    emit_now, hold_cap, out_free, push;
   ace_rsp_type             new_rsp;

   ace_div u_div_hi (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_hi_ff),
      .divisor  (tot_ff),
      .quotient (qhi),
      .busy     (busy_hi)
   );

   ace_div u_div_lo (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_lo_ff),
      .divisor  (tot_ff),
      .quotient (qlo),
      .busy     (busy_lo)
   );

   // renormalization decision on the current interval
   always_comb begin
      low_adj  = low_ff;
      high_adj = high_ff;
      if (high_ff < AR_HALF) begin
         step = STEP_EMIT0;
      end else if (low_ff >= AR_HALF) begin
         step     = STEP_EMIT1;
         low_adj  = low_ff - AR_HALF;
         high_adj = high_ff - AR_HALF;
      end else if (low_ff >= FIRST_QUARTER && high_ff < THIRD_QUARTER) begin
         step     = STEP_PEND;
         low_adj  = low_ff - FIRST_QUARTER;
         high_adj = high_ff - FIRST_QUARTER;
      end else begin
         step = STEP_DONE;
      end
   end

   always_comb begin
      if (pend_ff == PEND_MAX) begin
         pinc     = pend_ff;
         pinc_sat = 1'b1;
      end else begin
         pinc     = pend_ff + 1'b1;
         pinc_sat = sat_ff;
      end
   end

   assign hold_cap = count_ff == RES_CAP;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit_now = (cmd.step && (step == STEP_EMIT0 || step == STEP_EMIT1)) || cmd.flush;
   assign push     = (emit_now && hold_valid_ff && !hold_cap) || cmd.drain;
   assign high_wide = RANGE_W'(low_ff) + qhi - 1'b1;

   always_comb begin
      if (cmd.flush) begin
         new_rsp = make_rsp(low_ff >= FIRST_QUARTER, pinc, pinc_sat);
      end else begin
         new_rsp = make_rsp(step == STEP_EMIT1, pend_ff, sat_ff);
      end
   end

   always_comb begin
      low_in        = low_ff;
      high_in       = high_ff;
      pend_in       = pend_ff;
      sat_in        = sat_ff;
      finished_in   = finished_ff;
      range_in      = range_ff;
      cb_in         = cb_ff;
      ct_in         = ct_ff;
      tot_in        = tot_ff;
      prod_hi_in    = prod_hi_ff;
      prod_lo_in    = prod_lo_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      count_in      = count_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.load) begin
         range_in = RANGE_W'(high_ff) - RANGE_W'(low_ff) + 1'b1;
         cb_in    = req_data.cum_below;
         ct_in    = req_data.cum_through;
         tot_in   = req_data.freq_total;
         count_in = '0;
      end
      if (cmd.mul) begin
         prod_hi_in = PROD_W'(range_ff) * PROD_W'(ct_ff);
         prod_lo_in = PROD_W'(range_ff) * PROD_W'(cb_ff);
      end
      if (cmd.narrow) begin
         high_in = high_wide[CODE_BITS-1:0];
         low_in  = low_ff + qlo[CODE_BITS-1:0];
      end
      if (cmd.step && step != STEP_DONE) begin
         low_in  = {low_adj[CODE_BITS-2:0], 1'b0};
         high_in = {high_adj[CODE_BITS-2:0], 1'b1};
         if (step == STEP_PEND) begin
            pend_in = pinc;
            sat_in  = pinc_sat;
         end
      end
      if (cmd.flush) begin
         finished_in = 1'b1;
      end
      if (emit_now) begin
         pend_in = '0;
         sat_in  = 1'b0;
         if (hold_valid_ff && hold_cap) begin
            // result budget spent: drop the bit, flag the newest result
            hold_in.pending_overflow = 1'b1;
         end else begin
            hold_in       = new_rsp;
            hold_valid_in = 1'b1;
            count_in      = count_ff + 1'b1;
         end
      end
      if (cmd.drain) begin
         hold_valid_in = 1'b0;
      end
      if (push) begin
         rsp_data_in      = hold_ff;
         rsp_data_in.last = cmd.drain;
      end
   end

   assign rsp_valid_in = push || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff        <= '0;
         high_ff       <= CODE_TOP;
         pend_ff       <= '0;
         sat_ff        <= 1'b0;
         finished_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         low_ff        <= low_in;
         high_ff       <= high_in;
         pend_ff       <= pend_in;
         sat_ff        <= sat_in;
         finished_ff   <= finished_in;
         hold_valid_ff <= hold_valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      range_ff    <= range_in;
      cb_ff       <= cb_in;
      ct_ff       <= ct_in;
      tot_ff      <= tot_in;
      prod_hi_ff  <= prod_hi_in;
      prod_lo_ff  <= prod_lo_in;
      hold_ff     <= hold_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      status.req_flush  = req_data.kind == KIND_FLUSH;
      status.req_sym_ok = (req_data.freq_total != '0)
                       && (req_data.freq_total <= FREQ_LIMIT)
                       && (req_data.cum_through <= req_data.freq_total)
                       && ({1'b0, req_data.cum_below} < req_data.cum_through);
      status.finished   = finished_ff;
      status.div_busy   = busy_hi || busy_lo;
      status.q_ok       = qhi > qlo;
      status.step       = step;
      status.hold_valid = hold_valid_ff;
      status.hold_cap   = hold_cap;
      status.out_free   = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_interval_order: assert property (@(posedge clock) disable iff (reset)
      low_ff <= high_ff)
      else $error("interval low above high");

   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      finished_ff |=> finished_ff)
      else $error("finished flag cleared without reset");

   a_sat_at_max: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> pend_ff == PEND_MAX)
      else $error("pending saturation flag without full count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RES_CAP)
      else $error("result count beyond budget");

endmodule

[sv/ace_ctrl.sv]
// ----------------------------------------------------------------------------
// ace_ctrl: interval encoder sequencer
// Walks each request through multiply, divide, narrow and renormalize, and
// paces bit emission against the result register.
// ----------------------------------------------------------------------------
module ace_ctrl import ace_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ace_status_type status,
   output ace_cmd_type    cmd
);

   ace_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.finished) begin
                  state_in = ST_IDLE;
               end else if (status.req_flush) begin
                  state_in = ST_FLUSH;
               end else if (status.req_sym_ok) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_NARROW;
            end
         end
         ST_NARROW: begin
            if (status.q_ok) begin
               cmd.narrow = 1'b1;
               state_in   = ST_RENORM;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RENORM: begin
            case (status.step)
               STEP_DONE: begin
                  state_in = ST_DRAIN;
               end
               STEP_PEND: begin
                  cmd.step = 1'b1;
               end
               default: begin
                  // an emit pushes the held result, so it needs a free slot
                  if (!status.hold_valid || status.hold_cap || status.out_free) begin
                     cmd.step = 1'b1;
                  end
               end
            endcase
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.hold_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.drain = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_stall_outside_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul, cmd.div_start, cmd.narrow, cmd.step, cmd.flush,
                cmd.drain}))
      else $error("more than one datapath command");

   a_div_follows_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");

endmodule

[sv/arithmetic_coder_interval_encoder.sv]
// ----------------------------------------------------------------------------
// arithmetic_coder_interval_encoder: integer arithmetic coder, interval part
// Narrows the code interval per symbol request and emits code bits with their
// follow counts; a flush request closes the stream.
// ----------------------------------------------------------------------------
// One request at a time. A symbol request passes through accept, multiply,
// divider start, divide (the two bit-serial dividers, one quotient bit per
// cycle over the 32-bit product), narrow, the renormalization steps, a
// step that sees the interval settle and a drain that releases the held
// bit; each emitted bit can wait on a stalled result channel. A flush
// request passes through the flush and drain states. Results carry
// last on the final bit of the request; a request that emits nothing (invalid
// bounds, empty interval, no renormalization bits, or anything after a flush)
// returns no results. A result one deep is held back internally so the last
// flag can be set, and a separate result register lets the final bit wait
// while the next request is taken. follow_count saturates and
// pending_overflow marks a result whose follow count is wrong.
// No memories and no clearing pass: the block is ready right after reset.
// ----------------------------------------------------------------------------
module arithmetic_coder_interval_encoder import ace_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ace_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ace_rsp_type rsp_data
);

   ace_cmd_type    cmd;
   ace_status_type status;

   // sequencer: request intake, divider pacing, emission pacing
   ace_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // interval, pending count, arithmetic and result registers
   ace_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
